// ----- design/tfnu_pkg.sv -----
// ----------------------------------------------------------------------------
// tfnu_pkg
// shared types, codes and product schedule for the flat normal unindexer
// ----------------------------------------------------------------------------
package tfnu_pkg;

   localparam int SLOT_W = 12;
   localparam int VCNT_W = 13;
   localparam int POS_W  = 32;
   localparam int NRM_W  = 16;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_CORNER = 1'b1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_MISSING = 1'b1;

   typedef logic signed [POS_W-1:0] pos_type;
   typedef logic signed [NRM_W-1:0] nrm_type;

   typedef struct packed {
      logic    has;
      nrm_type nx;
      nrm_type ny;
      nrm_type nz;
   } ovr_type;

   typedef struct packed {
      logic busy;
      logic done;
   } nrm_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CALC,
      ST_EMIT,
      ST_ERROR
   } tfnu_state_type;

   typedef enum logic [3:0] {
      NS_IDLE,
      NS_LOAD,
      NS_MUL,
      NS_ACC,
      NS_MAG,
      NS_FIT,
      NS_SQRT,
      NS_DLOAD,
      NS_DIV,
      NS_DSTORE,
      NS_DONE
   } nrm_state_type;

   // cross product terms: c[t] +/- e[a] * e[b]
   localparam logic [2:0] PROD_A [6] = '{3'd1, 3'd2, 3'd2, 3'd0, 3'd0, 3'd1};
   localparam logic [2:0] PROD_B [6] = '{3'd5, 3'd4, 3'd3, 3'd5, 3'd4, 3'd3};
   localparam logic [1:0] PROD_T [6] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
   localparam logic       PROD_S [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

endpackage

// ----- design/triangle_flat_normal_unindexer_unit.sv -----
// ----------------------------------------------------------------------------
// triangle_flat_normal_unindexer_unit
// expands indexed triangles into unshared flat-shaded vertices
// ----------------------------------------------------------------------------
// A load request leaves the unit idle; a first or second corner passes through
// the fetch state back to idle. For the third corner of a good triangle the
// face normal is worked out before its first vertex shows: on one bit-serial
// multiplier (six cross product terms and three squares), a square root of
// one bit a cycle, rescaling of the cross product and three divides. The
// three vertices then leave one per cycle as rsp_ready allows. A bad triangle
// gives its single error response from the error state, after the fetch state.
// One request is in flight at a time.
module triangle_flat_normal_unindexer_unit import tfnu_pkg::*; #(
   parameter int VERTEX_SLOTS = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [VCNT_W-1:0]  csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic [SLOT_W-1:0]  req_slot,
   input  pos_type            req_pos_x,
   input  pos_type            req_pos_y,
   input  pos_type            req_pos_z,
   input  logic               req_has_override,
   input  nrm_type            req_over_nx,
   input  nrm_type            req_over_ny,
   input  nrm_type            req_over_nz,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pos_type            rsp_out_x,
   output pos_type            rsp_out_y,
   output pos_type            rsp_out_z,
   output nrm_type            rsp_norm_x,
   output nrm_type            rsp_norm_y,
   output nrm_type            rsp_norm_z,
   output logic [31:0]        rsp_vertex_index,
   output logic               rsp_status,
   output logic               rsp_last
);

   localparam int AW = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;
   localparam int XW = (AW > SLOT_W) ? AW : SLOT_W;

   tfnu_state_type state_ff, state_in;
   logic [VCNT_W-1:0] vcount_ff;
   logic [1:0]  phase_ff, emit_ff;
   logic        bad_ff, ok_ff;
   logic [31:0] count_ff;
   pos_type     cpos_ff [3][3];
   ovr_type     ovr_ff [3];
   logic [3*POS_W-1:0] mem [VERTEX_SLOTS];
   logic [3*POS_W-1:0] rd_ff;

   logic [XW-1:0] slot_x;
   logic [AW-1:0] addr;
   logic        req_acc, rsp_acc, in_range, slot_ok, wr_en, nrm_start;
   pos_type     rd_pos [3];
   nrm_status_type nstat;
   nrm_type     fnorm [3];
   ovr_type     cur_ovr;

   assign slot_x   = XW'(req_slot);
   assign addr     = slot_x[AW-1:0];
   assign req_acc  = req_valid && req_ready;
   assign rsp_acc  = rsp_valid && rsp_ready;
   assign in_range = 32'(req_slot) < 32'(VERTEX_SLOTS);
   assign slot_ok  = in_range && ({1'b0, req_slot} < vcount_ff);
   assign wr_en    = req_acc && (req_opcode == OP_LOAD) && in_range;

   assign rd_pos[0] = rd_ff[3*POS_W-1:2*POS_W];
   assign rd_pos[1] = rd_ff[2*POS_W-1:POS_W];
   assign rd_pos[2] = rd_ff[POS_W-1:0];

   // position table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= {req_pos_x, req_pos_y, req_pos_z};
      end
      rd_ff <= mem[addr];
   end

   tfnu_normal u_normal (
      .clock  (clock),
      .reset  (reset),
      .start  (nrm_start),
      .p0     (cpos_ff[0]),
      .p1     (cpos_ff[1]),
      .p2     (rd_pos),
      .stat   (nstat),
      .normal (fnorm)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_acc && req_opcode == OP_CORNER) state_in = ST_FETCH;
         ST_FETCH: begin
            if (phase_ff != 2'd2) begin
               state_in = ST_IDLE;
            end else if (bad_ff || !ok_ff) begin
               state_in = ST_ERROR;
            end else begin
               state_in = ST_CALC;
            end
         end
         ST_CALC:  if (nstat.done) state_in = ST_EMIT;
         ST_EMIT:  if (rsp_acc && emit_ff == 2'd2) state_in = ST_IDLE;
         ST_ERROR: if (rsp_acc) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT) || (state_ff == ST_ERROR);
      nrm_start = (state_ff == ST_FETCH) && (phase_ff == 2'd2) && !bad_ff && ok_ff;
      cur_ovr   = ovr_ff[emit_ff];
      if (state_ff == ST_EMIT) begin
         rsp_out_x        = cpos_ff[emit_ff][0];
         rsp_out_y        = cpos_ff[emit_ff][1];
         rsp_out_z        = cpos_ff[emit_ff][2];
         rsp_norm_x       = cur_ovr.has ? cur_ovr.nx : fnorm[0];
         rsp_norm_y       = cur_ovr.has ? cur_ovr.ny : fnorm[1];
         rsp_norm_z       = cur_ovr.has ? cur_ovr.nz : fnorm[2];
         rsp_vertex_index = count_ff;
         rsp_status       = STATUS_OK;
         rsp_last         = (emit_ff == 2'd2);
      end else begin
         rsp_out_x        = '0;
         rsp_out_y        = '0;
         rsp_out_z        = '0;
         rsp_norm_x       = '0;
         rsp_norm_y       = '0;
         rsp_norm_z       = '0;
         rsp_vertex_index = '0;
         rsp_status       = STATUS_MISSING;
         rsp_last         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         vcount_ff <= '0;
         phase_ff  <= '0;
         emit_ff   <= '0;
         bad_ff    <= 1'b0;
         count_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            vcount_ff <= csr_wr_data;
         end
         if (state_ff == ST_FETCH) begin
            if (phase_ff != 2'd2) begin
               bad_ff   <= bad_ff || !ok_ff;
               phase_ff <= phase_ff + 2'd1;
            end else begin
               bad_ff   <= 1'b0;
               phase_ff <= '0;
            end
         end
         if (state_ff == ST_EMIT && rsp_acc) begin
            count_ff <= count_ff + 32'd1;
            emit_ff  <= (emit_ff == 2'd2) ? 2'd0 : emit_ff + 2'd1;
         end
      end
   end

   // corner capture
   always_ff @(posedge clock) begin
      if (req_acc && req_opcode == OP_CORNER) begin
         ok_ff <= slot_ok;
         ovr_ff[phase_ff] <= '{has: req_has_override, nx: req_over_nx,
                               ny: req_over_ny, nz: req_over_nz};
      end
      if (state_ff == ST_FETCH) begin
         for (int i = 0; i < 3; i++) begin
            cpos_ff[phase_ff][i] <= ok_ff ? rd_pos[i] : '0;
         end
      end
   end

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response is pending");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_MISSING) |-> rsp_last)
      else $error("error response not marked last");

   a_vertices_follow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid)
      else $error("triangle vertices interrupted");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("corner phase out of range");

endmodule

// ----- design/tfnu_normal.sv -----
// ----------------------------------------------------------------------------
// tfnu_normal
// unit face normal of one triangle on a shared bit-serial multiplier,
// a bit-pair square root and a restoring divider
// ----------------------------------------------------------------------------
module tfnu_normal import tfnu_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  pos_type        p0 [3],
   input  pos_type        p1 [3],
   input  pos_type        p2 [3],
   output nrm_status_type stat,
   output nrm_type        normal [3]
);

   nrm_state_type state_ff, state_in;

   logic signed [31:0] e_ff [6];
   logic signed [63:0] c_ff [3];
   logic [63:0] m_ff, acc_ff, mcand_ff, sum_ff, rn_ff, res_ff, bit_ff;
   logic [31:0] mplier_ff, len_ff;
   logic [46:0] rem_ff, div_ff;
   logic [14:0] q_ff;
   logic [2:0]  idx_ff;
   logic [4:0]  cnt_ff;
   logic        sq_ff, neg_ff;
   nrm_type     n_ff [3];

   logic signed [32:0] diff [6];
   logic [32:0] dmag [6];
   logic [32:0] dor;
   logic [1:0]  k;
   logic [31:0] opa, opb;
   logic        opneg;
   logic [63:0] sroot_sum, res_nx, mor, cmag64;
   logic        sroot_ge;
   logic [31:0] cmag;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? 32'(-v) : 32'(v);
      return r;
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      logic [63:0] r;
      r = v[63] ? 64'(-v) : 64'(v);
      return r;
   endfunction

   // edges and pre-scale
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i]     = $signed({p1[i][31], p1[i]}) - $signed({p0[i][31], p0[i]});
         diff[3 + i] = $signed({p2[i][31], p2[i]}) - $signed({p0[i][31], p0[i]});
      end
      dor = '0;
      for (int i = 0; i < 6; i++) begin
         dmag[i] = diff[i][32] ? 33'(-diff[i]) : 33'(diff[i]);
         dor     = dor | dmag[i];
      end
      if (dor[32]) begin
         k = 2'd3;
      end else if (dor[31]) begin
         k = 2'd2;
      end else if (dor[30]) begin
         k = 2'd1;
      end else begin
         k = 2'd0;
      end
   end

   always_comb begin
      cmag64 = mag64(c_ff[idx_ff[1:0]]);
      cmag   = cmag64[31:0];
      if (sq_ff) begin
         opa   = cmag64[31:0];
         opb   = opa;
         opneg = 1'b0;
      end else begin
         opa   = mag32(e_ff[PROD_A[idx_ff]]);
         opb   = mag32(e_ff[PROD_B[idx_ff]]);
         opneg = e_ff[PROD_A[idx_ff]][31] ^ e_ff[PROD_B[idx_ff]][31];
      end
      mor = mag64(c_ff[0]) | mag64(c_ff[1]) | mag64(c_ff[2]);
      sroot_sum = res_ff + bit_ff;
      sroot_ge  = rn_ff >= sroot_sum;
      res_nx    = sroot_ge ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         NS_IDLE:   if (start) state_in = NS_LOAD;
         NS_LOAD:   state_in = NS_MUL;
         NS_MUL:    if (cnt_ff == 5'd31) state_in = NS_ACC;
         NS_ACC: begin
            if (!sq_ff && idx_ff == 3'd5) begin
               state_in = NS_MAG;
            end else if (sq_ff && idx_ff == 3'd2) begin
               state_in = NS_SQRT;
            end else begin
               state_in = NS_LOAD;
            end
         end
         NS_MAG:    state_in = NS_FIT;
         NS_FIT:    if (m_ff[63:31] == '0) state_in = NS_LOAD;
         NS_SQRT:   if (bit_ff[0]) state_in = NS_DLOAD;
         NS_DLOAD:  state_in = NS_DIV;
         NS_DIV:    if (cnt_ff == 5'd14) state_in = NS_DSTORE;
         NS_DSTORE: state_in = (idx_ff == 3'd2) ? NS_DONE : NS_DLOAD;
         NS_DONE:   state_in = NS_IDLE;
         default:   state_in = NS_IDLE;
      endcase
   end

   // status outputs
   always_comb begin
      stat.busy = (state_ff != NS_IDLE);
      stat.done = (state_ff == NS_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= NS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         NS_IDLE: begin
            if (start) begin
               for (int i = 0; i < 6; i++) begin
                  e_ff[i] <= 32'(diff[i] >>> k);
               end
               for (int i = 0; i < 3; i++) begin
                  c_ff[i] <= '0;
               end
               idx_ff <= '0;
               sq_ff  <= 1'b0;
               sum_ff <= '0;
            end
         end
         NS_LOAD: begin
            mcand_ff  <= 64'(opa);
            mplier_ff <= opb;
            neg_ff    <= opneg;
            acc_ff    <= '0;
            cnt_ff    <= '0;
         end
         NS_MUL: begin
            if (mplier_ff[0]) begin
               acc_ff <= acc_ff + mcand_ff;
            end
            mcand_ff  <= mcand_ff << 1;
            mplier_ff <= mplier_ff >> 1;
            cnt_ff    <= cnt_ff + 5'd1;
         end
         NS_ACC: begin
            if (sq_ff) begin
               sum_ff <= sum_ff + acc_ff;
               if (idx_ff == 3'd2) begin
                  rn_ff  <= sum_ff + acc_ff;
                  res_ff <= '0;
                  bit_ff <= 64'd1 << 62;
               end
            end else if (PROD_S[idx_ff] ^ neg_ff) begin
               c_ff[PROD_T[idx_ff]] <= c_ff[PROD_T[idx_ff]] - $signed(acc_ff);
            end else begin
               c_ff[PROD_T[idx_ff]] <= c_ff[PROD_T[idx_ff]] + $signed(acc_ff);
            end
            idx_ff <= (idx_ff == 3'd5 || (sq_ff && idx_ff == 3'd2)) ? 3'd0 : idx_ff + 3'd1;
         end
         NS_MAG: m_ff <= mor;
         NS_FIT: begin
            if (m_ff[63:31] != '0) begin
               for (int i = 0; i < 3; i++) begin
                  c_ff[i] <= c_ff[i] >>> 1;
               end
               m_ff <= m_ff >> 1;
            end else begin
               sq_ff <= 1'b1;
            end
         end
         NS_SQRT: begin
            if (sroot_ge) begin
               rn_ff <= rn_ff - sroot_sum;
            end
            res_ff <= res_nx;
            bit_ff <= bit_ff >> 2;
            if (bit_ff[0]) begin
               len_ff <= res_nx[31:0];
            end
         end
         NS_DLOAD: begin
            rem_ff <= 47'({cmag, 14'b0}) + 47'(len_ff[31:1]);
            div_ff <= 47'({len_ff, 14'b0});
            q_ff   <= '0;
            cnt_ff <= '0;
         end
         NS_DIV: begin
            if (rem_ff >= div_ff) begin
               rem_ff <= rem_ff - div_ff;
               q_ff   <= {q_ff[13:0], 1'b1};
            end else begin
               q_ff   <= {q_ff[13:0], 1'b0};
            end
            div_ff <= div_ff >> 1;
            cnt_ff <= cnt_ff + 5'd1;
         end
         NS_DSTORE: begin
            if (len_ff == '0) begin
               n_ff[idx_ff[1:0]] <= '0;
            end else if (c_ff[idx_ff[1:0]][63]) begin
               n_ff[idx_ff[1:0]] <= -$signed({1'b0, q_ff});
            end else begin
               n_ff[idx_ff[1:0]] <= $signed({1'b0, q_ff});
            end
            idx_ff <= idx_ff + 3'd1;
         end
         default: begin
         end
      endcase
   end

   assign normal = n_ff;

endmodule

// ----- test/triangle_flat_normal_unindexer_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_flat_normal_unindexer_unit_test
// checks vertex expansion, face normals and slot validation against a model
// ----------------------------------------------------------------------------
// Loads positions into the slot table, then sends triangles as three corner
// requests. A model in this file works out the expected vertices or the error
// response for each triangle. A separate process compares every response with
// the oldest expected one. Both sides pause at random.
// ----------------------------------------------------------------------------
module triangle_flat_normal_unindexer_unit_test;
   import tfnu_pkg::*;

   typedef struct {
      pos_type     x;
      pos_type     y;
      pos_type     z;
      nrm_type     nx;
      nrm_type     ny;
      nrm_type     nz;
      logic [31:0] index;
      logic        status;
      logic        last;
   } vertex_type;

   localparam int SLOTS = 4096;
   localparam int WATCHDOG_LIMIT = 20000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [VCNT_W-1:0] csr_wr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_opcode = OP_LOAD;
   logic [SLOT_W-1:0] req_slot = '0;
   pos_type           req_pos_x = '0;
   pos_type           req_pos_y = '0;
   pos_type           req_pos_z = '0;
   logic              req_has_override = 1'b0;
   nrm_type           req_over_nx = '0;
   nrm_type           req_over_ny = '0;
   nrm_type           req_over_nz = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   pos_type           rsp_out_x;
   pos_type           rsp_out_y;
   pos_type           rsp_out_z;
   nrm_type           rsp_norm_x;
   nrm_type           rsp_norm_y;
   nrm_type           rsp_norm_z;
   logic [31:0]       rsp_vertex_index;
   logic              rsp_status;
   logic              rsp_last;

   // model state
   pos_type           table_pos [SLOTS][3];
   bit                table_written [SLOTS];
   pos_type           held_pos [2][3];
   ovr_type           held_ovr [2];
   bit                held_bad;
   int                phase;
   logic [31:0]       next_index;
   logic [VCNT_W-1:0] vertex_count;

   vertex_type        expected_vertices [$];
   int                errors = 0;
   bit                quiet = 1'b0;
   int                idle_cycles = 0;

   always #4 clock = ~clock;

   triangle_flat_normal_unindexer_unit i_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_opcode(req_opcode), .req_slot(req_slot),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_has_override(req_has_override),
      .req_over_nx(req_over_nx), .req_over_ny(req_over_ny),
      .req_over_nz(req_over_nz),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z),
      .rsp_norm_x(rsp_norm_x), .rsp_norm_y(rsp_norm_y),
      .rsp_norm_z(rsp_norm_z),
      .rsp_vertex_index(rsp_vertex_index), .rsp_status(rsp_status),
      .rsp_last(rsp_last)
   );

   function automatic longint abs64(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint floor_shift(longint v, int k);
      return v >>> k;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   task automatic fit_range(ref longint v [6], input int cnt, input longint unsigned lim);
      longint unsigned m = 0;
      int k = 0;
      for (int i = 0; i < cnt; i++)
         if (longint'(abs64(v[i])) > m) m = abs64(v[i]);
      while ((m >> k) >= lim) k++;
      if (k != 0)
         for (int i = 0; i < cnt; i++) v[i] = floor_shift(v[i], k);
   endtask

   task automatic face_normal(input pos_type p [3][3], output nrm_type n [3]);
      longint e [6];
      longint c [6];
      longint unsigned sum = 0;
      longint unsigned len;
      longint unsigned q;
      for (int i = 0; i < 3; i++) begin
         e[i] = longint'(p[1][i]) - longint'(p[0][i]);
         e[3+i] = longint'(p[2][i]) - longint'(p[0][i]);
      end
      fit_range(e, 6, 64'd1 << 30);
      c[0] = e[1] * e[5] - e[2] * e[4];
      c[1] = e[2] * e[3] - e[0] * e[5];
      c[2] = e[0] * e[4] - e[1] * e[3];
      c[3] = 0; c[4] = 0; c[5] = 0;
      fit_range(c, 3, 64'd1 << 31);
      for (int i = 0; i < 3; i++) sum += abs64(c[i]) * abs64(c[i]);
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         if (len == 0) begin
            n[i] = '0;
         end else begin
            q = (abs64(c[i]) * 16384 + len / 2) / len;
            n[i] = c[i] < 0 ? nrm_type'(-longint'(q)) : nrm_type'(q);
         end
      end
   endtask

   task automatic predict_request(input logic op, input logic [SLOT_W-1:0] s,
                                  input pos_type px, pos_type py, pos_type pz,
                                  input ovr_type ov);
      bit ok;
      pos_type p [3][3];
      ovr_type o [3];
      nrm_type fn [3];
      vertex_type vx;
      if (op == OP_LOAD) begin
         table_pos[s][0] = px; table_pos[s][1] = py; table_pos[s][2] = pz;
         table_written[s] = 1'b1;
         return;
      end
      ok = s < vertex_count;
      if (phase < 2) begin
         for (int i = 0; i < 3; i++) held_pos[phase][i] = ok ? table_pos[s][i] : '0;
         held_ovr[phase] = ov;
         if (!ok) held_bad = 1'b1;
         phase++;
         return;
      end
      phase = 0;
      if (!ok || held_bad) begin
         held_bad = 1'b0;
         vx = '{'0, '0, '0, '0, '0, '0, '0, STATUS_MISSING, 1'b1};
         expected_vertices = {expected_vertices, vx};
         return;
      end
      p[0] = held_pos[0]; p[1] = held_pos[1];
      for (int i = 0; i < 3; i++) p[2][i] = table_pos[s][i];
      o[0] = held_ovr[0]; o[1] = held_ovr[1]; o[2] = ov;
      face_normal(p, fn);
      for (int v = 0; v < 3; v++) begin
         vx.x = p[v][0]; vx.y = p[v][1]; vx.z = p[v][2];
         vx.nx = o[v].has ? o[v].nx : fn[0];
         vx.ny = o[v].has ? o[v].ny : fn[1];
         vx.nz = o[v].has ? o[v].nz : fn[2];
         vx.index = next_index;
         vx.status = STATUS_OK;
         vx.last = (v == 2);
         next_index++;
         expected_vertices = {expected_vertices, vx};
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   function automatic bit pause_now();
      return !quiet && $urandom_range(99) < 8;
   endfunction

   task automatic send_request(input logic op, input logic [SLOT_W-1:0] s,
                               input pos_type px, pos_type py, pos_type pz,
                               input ovr_type ov);
      while (pause_now()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op; req_slot <= s;
      req_pos_x <= px; req_pos_y <= py; req_pos_z <= pz;
      req_has_override <= ov.has;
      req_over_nx <= ov.nx; req_over_ny <= ov.ny; req_over_nz <= ov.nz;
      do @(posedge clock); while (!req_ready);
      predict_request(op, s, px, py, pz, ov);
      @(negedge clock);
   endtask

   task automatic load_slot(input logic [SLOT_W-1:0] s,
                            input pos_type px, pos_type py, pos_type pz);
      send_request(OP_LOAD, s, px, py, pz, '{1'b0, '0, '0, '0});
   endtask

   function automatic ovr_type random_override();
      ovr_type o;
      o.has = $urandom_range(2) == 0;
      o.nx = nrm_type'($urandom_range(32768) - 16384);
      o.ny = nrm_type'($urandom_range(32768) - 16384);
      o.nz = nrm_type'($urandom_range(32768) - 16384);
      return o;
   endfunction

   task automatic send_corner(input logic [SLOT_W-1:0] s, input ovr_type ov);
      send_request(OP_CORNER, s, pos_type'($urandom), pos_type'($urandom),
                   pos_type'($urandom), ov);
   endtask

   task automatic send_triangle(input logic [SLOT_W-1:0] a, b, c);
      send_corner(a, random_override());
      send_corner(b, random_override());
      send_corner(c, random_override());
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_vertices.size() != 0) @(negedge clock);
      repeat (450) @(negedge clock);
   endtask

   task automatic set_vertex_count(input logic [VCNT_W-1:0] n);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= n;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      vertex_count = n;
   endtask

   // only slots that were written may be referenced as valid
   function automatic logic [SLOT_W-1:0] pick_slot(input bit want_valid);
      logic [SLOT_W-1:0] s;
      if (!want_valid && vertex_count < SLOTS)
         return SLOT_W'($urandom_range(SLOTS - 1, vertex_count));
      do s = SLOT_W'($urandom_range(vertex_count - 1)); while (!table_written[s]);
      return s;
   endfunction

   task automatic test_directed();
      ovr_type none;
      ovr_type extreme;
      none = '{1'b0, '0, '0, '0};
      extreme = '{1'b1, -16'sd16384, 16'sd16384, 16'h7fff};
      set_vertex_count(13'd8);
      load_slot(12'd0, 32'sh80000000, 32'sh7fffffff, 0);
      load_slot(12'd1, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
      load_slot(12'd2, 0, 32'sh7fffffff, 32'sh80000000);
      load_slot(12'd3, 32'h00010000, 0, 0);
      load_slot(12'd4, 0, 32'h00010000, 0);
      load_slot(12'd5, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      load_slot(12'd6, 32'h00020000, 0, 0);
      load_slot(12'd7, 0, 0, 32'h00010000);
      load_slot(12'hfff, 32'h5555aaaa, 32'haaaa5555, 32'h0f0f0f0f);
      send_triangle(12'd0, 12'd1, 12'd2);          // widest edges
      send_corner(12'd7, none); send_corner(12'd3, none); send_corner(12'd4, extreme);
      send_corner(12'd7, none); send_corner(12'd3, none);
      send_corner(12'd6, none);                    // normal along -y
      send_corner(12'd5, none); send_corner(12'd5, none);
      send_corner(12'd5, none);                    // one point
      send_triangle(12'hfff, 12'd0, 12'd1);        // bad first corner
      send_corner(12'd3, none); load_slot(12'd6, 0, 0, 32'h00030000);
      send_corner(12'd4, none); send_corner(12'd6, none);  // load mid triangle
      send_triangle(12'd0, 12'd1, 12'd9);          // bad last corner
   endtask

   task automatic test_random(input int count);
      int r;
      for (int i = 0; i < count; i++) begin
         quiet = (i >= count / 3 && i < count / 2);
         r = $urandom_range(99);
         if (r < 20)
            load_slot(SLOT_W'($urandom_range(SLOTS - 1)), pos_type'($urandom),
                      pos_type'($urandom), pos_type'($urandom));
         else if (r < 75 || vertex_count == 0)
            send_corner(pick_slot(vertex_count != 0 && $urandom_range(9) != 0),
                        random_override());
         else
            send_triangle(pick_slot(1'b1), pick_slot(1'b1), pick_slot(1'b1));
         if (i == count / 2) drain();
      end
      quiet = 1'b0;
   endtask

   task automatic test_extreme_counts();
      set_vertex_count(13'd0);
      send_triangle(12'd0, 12'hfff, 12'd1);
      for (int s = 0; s < SLOTS; s += 1)
         if (!table_written[s] && (s < 16 || s >= SLOTS - 16))
            load_slot(SLOT_W'(s), pos_type'($urandom), pos_type'($urandom),
                      pos_type'($urandom));
      set_vertex_count(13'd4096);
      send_triangle(12'hfff, 12'hffe, 12'd0);
      send_triangle(12'hff0, 12'h00f, 12'hfff);
   endtask

   // response checker
   always @(posedge clock) begin
      vertex_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_vertices.size() == 0) begin
            report_mismatch("response with nothing expected");
         end else begin
            e = expected_vertices.pop_front();
            if (rsp_out_x !== e.x) report_mismatch($sformatf("x %h exp %h", rsp_out_x, e.x));
            if (rsp_out_y !== e.y) report_mismatch($sformatf("y %h exp %h", rsp_out_y, e.y));
            if (rsp_out_z !== e.z) report_mismatch($sformatf("z %h exp %h", rsp_out_z, e.z));
            if (rsp_norm_x !== e.nx)
               report_mismatch($sformatf("nx %h exp %h", rsp_norm_x, e.nx));
            if (rsp_norm_y !== e.ny)
               report_mismatch($sformatf("ny %h exp %h", rsp_norm_y, e.ny));
            if (rsp_norm_z !== e.nz)
               report_mismatch($sformatf("nz %h exp %h", rsp_norm_z, e.nz));
            if (rsp_vertex_index !== e.index)
               report_mismatch($sformatf("index %h exp %h", rsp_vertex_index, e.index));
            if (rsp_status !== e.status)
               report_mismatch($sformatf("status %b exp %b", rsp_status, e.status));
            if (rsp_last !== e.last)
               report_mismatch($sformatf("last %b exp %b", rsp_last, e.last));
         end
      end
   end

   always @(negedge clock) rsp_ready <= !pause_now();

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      phase = 0; held_bad = 1'b0; next_index = '0; vertex_count = '0;
      for (int s = 0; s < SLOTS; s++) table_written[s] = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      set_vertex_count(13'd64);
      for (int s = 0; s < 64; s++)
         load_slot(SLOT_W'(s), pos_type'($urandom), pos_type'($urandom),
                   pos_type'($urandom));
      test_random(35);
      set_vertex_count(13'd32);
      test_random(35);
      test_extreme_counts();
      drain();
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
